[design/tlt_pkg.sv]
// Shared types, codes and sizes of the track lifecycle table.
package tlt_pkg;

    // Table geometry.
    localparam int MAX_TRACKS = 64;
    localparam int COUNT_BITS = 8;
    localparam int SLOT_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CFG_W      = 8;
    localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int ID_W       = 32;
    localparam int TIME_W     = 48;

    localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] HIT_LIMIT_RST  = CFG_W'(3);
    localparam logic [CFG_W-1:0] MISS_LIMIT_RST = CFG_W'(5);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_HIT    = 3'd1,
        OP_MISS   = 3'd2,
        OP_NOTE   = 3'd3,
        OP_QUERY  = 3'd4,
        OP_UPDATE = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        RES_NONE      = 3'd0,
        RES_INIT      = 3'd1,
        RES_CONFIRMED = 3'd2,
        RES_DELETED   = 3'd3,
        RES_UPDATED   = 3'd4,
        RES_TIME      = 3'd5,
        RES_NOT_FOUND = 3'd6,
        RES_FULL      = 3'd7
    } res_t;

    typedef enum logic [1:0] {
        ST_TENTATIVE = 2'd0,
        ST_CONFIRMED = 2'd1,
        ST_COASTING  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FIN  = 2'd2
    } state_t;

    // One slot of the table as it is kept in memory.
    typedef struct packed {
        logic [ID_W-1:0]       id;
        status_t               status;
        logic [COUNT_BITS-1:0] hits;
        logic [COUNT_BITS-1:0] misses;
        logic [TIME_W-1:0]     last_time;
    } slot_entry_t;

endpackage

[design/track_lifecycle_table.sv]
// Track lifecycle table: slot memory, scan sequencer and event result register.
//
// This block keeps up to MAX_TRACKS tracks with N-hit confirmation and M-miss
// deletion. Each input word is one event (add, hit, miss, note observation,
// query time, report update) and yields exactly one result word. Track slots
// live in a single-port synchronous memory with a registered read port;
// per-slot valid bits are flip-flops cleared by reset, so no clearing pass is
// needed and the block takes its first word right after reset. Every event
// that needs a slot scans the memory from slot 0 upward, one slot per cycle,
// and stops at the first match: the lowest free slot for add, or the lowest
// valid slot holding the given id for the other events. A miss in the scan
// (unknown id, full table) reads every slot, and the unused op codes skip the
// scan. The memory read port, read once per cycle by the scan, sets the scan
// rate. After the scan the slot is read, modified and written back; since a
// single event is in flight at a time, a read never overlaps a pending write
// to the same slot. The result sits in an output register, so a new input
// word is accepted while an earlier result still waits for the consumer. The
// thresholds are written through a small configuration port that is always
// ready; index 0 is the confirm threshold and index 1 is the delete threshold.
module track_lifecycle_table (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlt_pkg::CFG_W-1:0]    cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  tlt_pkg::op_t                 op,
    input  logic [tlt_pkg::ID_W-1:0]     track_id,
    input  logic [tlt_pkg::TIME_W-1:0]   timestamp,

    output logic                         out_valid,
    input  logic                         out_stall,
    output tlt_pkg::res_t                event_res,
    output logic [tlt_pkg::ID_W-1:0]     event_track_id,
    output logic [tlt_pkg::TIME_W-1:0]   event_time,
    output tlt_pkg::status_t             event_status
);
    import tlt_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] hit_limit_reg;
    logic [CFG_W-1:0] miss_limit_reg;

    // Sequencer state.
    state_t state_reg;
    state_t state_next;

    // The event under work.
    op_t               cmd_op_reg;
    logic [ID_W-1:0]   cmd_id_reg;
    logic [TIME_W-1:0] cmd_time_reg;

    // Scan address generator and the check stage registered right behind it.
    logic [SLOT_W-1:0] issue_addr_reg;
    logic              issue_active_reg;
    logic              chk_valid_reg;
    logic [SLOT_W-1:0] chk_idx_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [MAX_TRACKS-1:0] valid_reg;
    logic [ID_W-1:0]       id_counter_reg;

    // Slot memory and its registered read data.
    slot_entry_t entry_mem [MAX_TRACKS];
    slot_entry_t rd_q;
    slot_entry_t wr_entry;

    // Output register.
    logic              out_valid_reg;
    res_t              res_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [TIME_W-1:0] res_time_reg;
    status_t           res_status_reg;

    // Control from the sequencer.
    logic accept;
    logic ren;
    logic load;
    logic out_free;
    logic chk_match;
    logic chk_last;

    // Result and write-back of the finishing step.
    res_t              res_next;
    logic [ID_W-1:0]   res_id_next;
    logic [TIME_W-1:0] res_time_next;
    status_t           res_status_next;
    logic              we_req;
    logic              valid_set;
    logic              valid_clr;
    logic              mem_we;

    logic [COUNT_BITS-1:0] hits_inc;
    logic [COUNT_BITS-1:0] misses_inc;
    logic                  hit_confirms;
    logic                  miss_deletes;

    // ------------------------------------------------------------------
    // Configuration port. Writes land at once; indexes past the list are
    // ignored.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_limit_reg  <= HIT_LIMIT_RST;
            miss_limit_reg <= MISS_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HIT_LIMIT:  hit_limit_reg  <= cfg_data;
                CFG_MISS_LIMIT: miss_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scan check. An add looks for a free slot; every other event looks
    // for a valid slot holding the requested id.
    // ------------------------------------------------------------------
    always_comb
    begin
        chk_match = 1'b0;
        if (chk_valid_reg)
        begin
            if (cmd_op_reg == OP_ADD)
                chk_match = !valid_reg[chk_idx_reg];
            else
                chk_match = valid_reg[chk_idx_reg] && (rd_q.id == cmd_id_reg);
        end
    end

    assign chk_last = chk_valid_reg && (chk_idx_reg == LAST_SLOT);
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (op > OP_UPDATE) ? S_FIN : S_SCAN;
            end
            S_SCAN:
            begin
                if (chk_match || chk_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. Reads stop the cycle a match shows up so that the
    // matched slot stays in the read register for the finishing step.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = 1'b1;
        ren      = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            S_IDLE:
                in_stall = 1'b0;
            S_SCAN:
                ren = issue_active_reg && !chk_match;
            S_FIN:
                load = out_free;
            default:
            begin
            end
        endcase
    end

    assign accept = in_valid && !in_stall;
    assign mem_we = load && we_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Event capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg   <= op;
            cmd_id_reg   <= track_id;
            cmd_time_reg <= timestamp;
        end
    end

    // Scan address generator and check stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_addr_reg   <= '0;
            issue_active_reg <= 1'b0;
            chk_valid_reg    <= 1'b0;
            chk_idx_reg      <= '0;
            found_reg        <= 1'b0;
            slot_reg         <= '0;
        end
        else
        begin
            chk_valid_reg <= ren;
            if (ren)
                chk_idx_reg <= issue_addr_reg;

            if (accept)
            begin
                issue_addr_reg   <= '0;
                issue_active_reg <= 1'b1;
                found_reg        <= 1'b0;
            end
            else if (ren)
            begin
                if (issue_addr_reg == LAST_SLOT)
                    issue_active_reg <= 1'b0;
                else
                    issue_addr_reg <= issue_addr_reg + SLOT_W'(1);
            end

            if (state_reg == S_SCAN && chk_match)
            begin
                found_reg <= 1'b1;
                slot_reg  <= chk_idx_reg;
            end
        end
    end

    // Slot memory: one write or one read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[slot_reg] <= wr_entry;
        if (ren)
            rd_q <= entry_mem[issue_addr_reg];
    end

    // ------------------------------------------------------------------
    // Finishing step: result word and slot write-back.
    // ------------------------------------------------------------------
    assign hits_inc     = (rd_q.hits == CNT_MAX) ? CNT_MAX : rd_q.hits + COUNT_BITS'(1);
    assign misses_inc   = (rd_q.misses == CNT_MAX) ? CNT_MAX
                                                   : rd_q.misses + COUNT_BITS'(1);
    assign hit_confirms = CMP_W'(hits_inc) >= CMP_W'(hit_limit_reg);
    assign miss_deletes = CMP_W'(misses_inc) >= CMP_W'(miss_limit_reg);

    always_comb
    begin
        res_next        = RES_NONE;
        res_id_next     = cmd_id_reg;
        res_time_next   = '0;
        res_status_next = ST_TENTATIVE;
        wr_entry        = rd_q;
        we_req          = 1'b0;
        valid_set       = 1'b0;
        valid_clr       = 1'b0;

        if (cmd_op_reg == OP_ADD)
        begin
            if (found_reg)
            begin
                wr_entry.id        = id_counter_reg;
                wr_entry.status    = ST_TENTATIVE;
                wr_entry.hits      = COUNT_BITS'(1);
                wr_entry.misses    = '0;
                wr_entry.last_time = cmd_time_reg;
                we_req             = 1'b1;
                valid_set          = 1'b1;
                res_next           = RES_INIT;
                res_id_next        = id_counter_reg;
                res_time_next      = cmd_time_reg;
            end
            else
            begin
                res_next      = RES_FULL;
                res_id_next   = '0;
                res_time_next = cmd_time_reg;
            end
        end
        else if (cmd_op_reg > OP_UPDATE)
        begin
            res_next = RES_NONE;
        end
        else if (!found_reg)
        begin
            res_next = RES_NOT_FOUND;
        end
        else
        begin
            res_time_next   = rd_q.last_time;
            res_status_next = rd_q.status;
            case (cmd_op_reg)
                OP_HIT:
                begin
                    wr_entry.hits   = hits_inc;
                    wr_entry.misses = '0;
                    we_req          = 1'b1;
                    if (hit_confirms)
                    begin
                        wr_entry.status = ST_CONFIRMED;
                        res_status_next = ST_CONFIRMED;
                        if (rd_q.status != ST_CONFIRMED)
                            res_next = RES_CONFIRMED;
                    end
                end
                OP_MISS:
                begin
                    if (miss_deletes)
                    begin
                        valid_clr = 1'b1;
                        res_next  = RES_DELETED;
                    end
                    else
                    begin
                        wr_entry.misses = misses_inc;
                        wr_entry.hits   = '0;
                        we_req          = 1'b1;
                        if (rd_q.status == ST_CONFIRMED || rd_q.status == ST_COASTING)
                        begin
                            wr_entry.status = ST_COASTING;
                            res_status_next = ST_COASTING;
                        end
                    end
                end
                OP_NOTE:
                begin
                    wr_entry.last_time = cmd_time_reg;
                    we_req             = 1'b1;
                    res_time_next      = cmd_time_reg;
                end
                OP_QUERY:
                    res_next = RES_TIME;
                default:
                begin
                    res_next      = RES_UPDATED;
                    res_time_next = cmd_time_reg;
                end
            endcase
        end
    end

    // Valid bits and id counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            id_counter_reg <= '0;
        end
        else if (load)
        begin
            if (valid_set)
            begin
                valid_reg[slot_reg] <= 1'b1;
                id_counter_reg      <= id_counter_reg + ID_W'(1);
            end
            else if (valid_clr)
                valid_reg[slot_reg] <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg        <= res_next;
            res_id_reg     <= res_id_next;
            res_time_reg   <= res_time_next;
            res_status_reg <= res_status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = res_reg;
    assign event_track_id = res_id_reg;
    assign event_time     = res_time_reg;
    assign event_status   = res_status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A new track always lands in a slot that then reads as valid.
    a_init_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (load && valid_set) |=> valid_reg[$past(slot_reg)])
        else $error("initiated track did not mark its slot valid");

    // While the result waits, no read may disturb the matched slot data.
    a_fin_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_free) |=>
            (state_reg == S_FIN && !ren && $stable(slot_reg)))
        else $error("slot data changed while the result was waiting");

    // A result appears only out of the finishing step.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result word raised outside the finishing step");

    // The id counter moves only with an initiated track.
    a_counter_on_init: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(id_counter_reg) |-> (out_valid_reg && res_reg == RES_INIT))
        else $error("id counter moved without an initiated result");

endmodule
